/* rtl/sbfd_pkg.sv */
// Shared types and constants for the soft-bit frame deframer.
// No dependencies; used by sbfd_frame and soft_bit_frame_deframer_core.
package sbfd_pkg;

   localparam int unsigned WORD_W              = 16;
   localparam int unsigned BYTE_W              = 8;
   localparam int unsigned MAX_FRAME_BYTES_DEF = 10;

   localparam logic [WORD_W-1:0] ONE_WORD = 16'h0081;

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_BYTE   = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADLEN = 2'd2,
      ST_TRUNC  = 2'd3
   } status_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } result_type;

endpackage

/* rtl/sbfd_frame.sv */
// Frame state machine, bit packer and result register of the deframer.
// Depends on sbfd_pkg.
module sbfd_frame #(
   parameter int unsigned MaxFrameBytes = sbfd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_go,
   input  logic                          advance,
   input  logic [sbfd_pkg::WORD_W-1:0]   word,
   input  logic                          stream_end,
   output sbfd_pkg::result_type          result
);

   localparam int unsigned FB_W  = $clog2(MaxFrameBytes + 1);
   localparam int unsigned CNT_W = sbfd_pkg::WORD_W - 3;

   sbfd_pkg::phase_type  phase_ff, phase_in;
   logic [FB_W-1:0]      frame_bytes_ff, frame_bytes_in;
   logic [FB_W-1:0]      bytes_done_ff, bytes_done_in;
   logic [2:0]           bit_index_ff, bit_index_in;
   logic [6:0]           bit_shift_ff, bit_shift_in;
   sbfd_pkg::result_type result_ff, result_in;
   logic                 valid_ff, valid_in;

   logic [CNT_W-1:0] count;
   logic             len_bad;
   logic             len_zero;
   logic             bit_val;
   logic             byte_full;
   logic [FB_W-1:0]  bytes_next;
   logic             frame_last;

   assign count      = word[sbfd_pkg::WORD_W-1:3];
   assign len_bad    = count > CNT_W'(MaxFrameBytes);
   assign len_zero   = count == '0;
   assign bit_val    = word == sbfd_pkg::ONE_WORD;
   assign byte_full  = bit_index_ff == 3'd7;
   assign bytes_next = bytes_done_ff + FB_W'(1);
   assign frame_last = bytes_next >= frame_bytes_ff;

   always_comb begin
      unique case (phase_ff)
         sbfd_pkg::PH_LEN: begin
            if (len_bad || len_zero || stream_end) begin
               phase_in = sbfd_pkg::PH_SYNC;
            end else begin
               phase_in = sbfd_pkg::PH_DATA;
            end
         end
         sbfd_pkg::PH_DATA: begin
            if (stream_end || (byte_full && frame_last)) begin
               phase_in = sbfd_pkg::PH_SYNC;
            end else begin
               phase_in = sbfd_pkg::PH_DATA;
            end
         end
         default: begin
            phase_in = stream_end ? sbfd_pkg::PH_SYNC : sbfd_pkg::PH_LEN;
         end
      endcase
   end

   always_comb begin
      frame_bytes_in       = '0;
      bytes_done_in        = '0;
      bit_index_in         = '0;
      bit_shift_in         = '0;
      result_in.valid      = 1'b0;
      result_in.status     = sbfd_pkg::ST_BYTE;
      result_in.byte_value = '0;
      result_in.last_byte  = 1'b0;
      unique case (phase_ff)
         sbfd_pkg::PH_LEN: begin
            result_in.valid = len_bad || len_zero || stream_end;
            priority if (len_bad) begin
               result_in.status = sbfd_pkg::ST_BADLEN;
            end else if (len_zero) begin
               result_in.status = sbfd_pkg::ST_EMPTY;
            end else if (stream_end) begin
               result_in.status = sbfd_pkg::ST_TRUNC;
            end else begin
               frame_bytes_in = count[FB_W-1:0];
            end
         end
         sbfd_pkg::PH_DATA: begin
            if (!byte_full) begin
               if (stream_end) begin
                  result_in.valid  = 1'b1;
                  result_in.status = sbfd_pkg::ST_TRUNC;
               end else begin
                  frame_bytes_in = frame_bytes_ff;
                  bytes_done_in  = bytes_done_ff;
                  bit_index_in   = bit_index_ff + 3'd1;
                  bit_shift_in   = {bit_shift_ff[5:0], bit_val};
               end
            end else begin
               result_in.valid = 1'b1;
               priority if (frame_last) begin
                  result_in.byte_value = {bit_shift_ff, bit_val};
                  result_in.last_byte  = 1'b1;
               end else if (stream_end) begin
                  result_in.status = sbfd_pkg::ST_TRUNC;
               end else begin
                  result_in.byte_value = {bit_shift_ff, bit_val};
                  frame_bytes_in       = frame_bytes_ff;
                  bytes_done_in        = bytes_next;
               end
            end
         end
         default: begin
            if (stream_end) begin
               result_in.valid  = 1'b1;
               result_in.status = sbfd_pkg::ST_TRUNC;
            end
         end
      endcase
   end

   assign valid_in = step_go ? result_in.valid : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= sbfd_pkg::PH_SYNC;
         frame_bytes_ff <= '0;
         bytes_done_ff  <= '0;
         bit_index_ff   <= '0;
         bit_shift_ff   <= '0;
         valid_ff       <= 1'b0;
      end else begin
         if (step_go) begin
            phase_ff       <= phase_in;
            frame_bytes_ff <= frame_bytes_in;
            bytes_done_ff  <= bytes_done_in;
            bit_index_ff   <= bit_index_in;
            bit_shift_ff   <= bit_shift_in;
         end
         if (advance) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      result       = result_ff;
      result.valid = valid_ff;
   end

`ifndef SYNTH
   a_bits_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff != 3'd0 |-> phase_ff == sbfd_pkg::PH_DATA)
      else $error("bit index set outside the payload phase");

   a_frame_count_sane: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sbfd_pkg::PH_DATA |->
         (frame_bytes_ff != '0 && bytes_done_ff < frame_bytes_ff))
      else $error("frame byte counters out of range in payload phase");

   a_last_returns_sync: assert property (@(posedge clock) disable iff (reset)
      step_go && result_in.valid && result_in.last_byte |=>
         phase_ff == sbfd_pkg::PH_SYNC)
      else $error("final byte did not return the deframer to sync");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      valid_ff && result_ff.status != sbfd_pkg::ST_BYTE |->
         (result_ff.byte_value == '0 && !result_ff.last_byte))
      else $error("status transfer carries byte data");
`endif

endmodule

/* rtl/soft_bit_frame_deframer_core.sv */
// Top level of the soft-bit frame deframer: input register and handshakes.
// Depends on sbfd_pkg and sbfd_frame.
//
//   Channel   Direction   Ports                                        Transfer when
//   req       in          req_valid, req_stall, req_word,              valid && !stall
//                         req_stream_end
//   rsp       out         rsp_valid, rsp_stall, rsp_status,            valid && !stall
//                         rsp_byte_value, rsp_last_byte
//
// One word is taken every cycle unless req_stall is high; a word's result, if it
// gives one, passes through the input register and then the result register.
// Reset is synchronous and returns the deframer to expecting a sync word.
// A stall on rsp holds the result register and then backs up into req.
module soft_bit_frame_deframer_core #(
   parameter int unsigned MaxFrameBytes = sbfd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sbfd_pkg::WORD_W-1:0]   req_word,
   input  logic                          req_stream_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [sbfd_pkg::BYTE_W-1:0]   rsp_byte_value,
   output logic                          rsp_last_byte
);

   logic                        in_valid_ff, in_valid_in;
   logic [sbfd_pkg::WORD_W-1:0] word_ff;
   logic                        end_ff;
   logic                        advance;
   logic                        accept;
   sbfd_pkg::result_type        result;

   assign advance   = !(result.valid && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
         end_ff  <= req_stream_end;
      end
   end

   sbfd_frame #(
      .MaxFrameBytes (MaxFrameBytes)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .step_go    (in_valid_ff && advance),
      .advance    (advance),
      .word       (word_ff),
      .stream_end (end_ff),
      .result     (result)
   );

   assign rsp_valid      = result.valid;
   assign rsp_status     = result.status;
   assign rsp_byte_value = result.byte_value;
   assign rsp_last_byte  = result.last_byte;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for soft_bit_frame_deframer_core: directed frames, then random traffic.
// It predicts every result from its own model of the frame parser and compares each rsp transfer.
// Depends on sbfd_pkg and the RTL of soft_bit_frame_deframer_core.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned MAX_BYTES = sbfd_pkg::MAX_FRAME_BYTES_DEF;

   typedef struct {
      sbfd_pkg::status_type        status;
      logic [sbfd_pkg::BYTE_W-1:0] byte_value;
      logic                        last_byte;
   } deframed_type;

   logic                        clock;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_stall;
   logic [sbfd_pkg::WORD_W-1:0] req_word       = '0;
   logic                        req_stream_end = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall      = 1'b0;
   logic [1:0]                  rsp_status;
   logic [sbfd_pkg::BYTE_W-1:0] rsp_byte_value;
   logic                        rsp_last_byte;

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned words_sent        = 0;
   int unsigned mismatch_count    = 0;

   deframed_type pending_results[$];

   // Model of the deframer state.
   sbfd_pkg::phase_type dfr_phase       = sbfd_pkg::PH_SYNC;
   logic [3:0]          dfr_frame_bytes = '0;
   logic [3:0]          dfr_bytes_done  = '0;
   logic [2:0]          dfr_bit_index   = '0;
   logic [6:0]          dfr_bit_shift   = '0;

   soft_bit_frame_deframer_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last_byte  (rsp_last_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("soft_bit_frame_deframer_core test failed");
      $finish;
   end

   function automatic void restart_frame();
      dfr_phase       = sbfd_pkg::PH_SYNC;
      dfr_frame_bytes = '0;
      dfr_bytes_done  = '0;
      dfr_bit_index   = '0;
      dfr_bit_shift   = '0;
   endfunction

   function automatic void expect_result(input sbfd_pkg::status_type status,
                                         input logic [sbfd_pkg::BYTE_W-1:0] value,
                                         input logic last);
      deframed_type item;
      item.status     = status;
      item.byte_value = value;
      item.last_byte  = last;
      pending_results.push_back(item);
   endfunction

   function automatic void deframe_word(input logic [sbfd_pkg::WORD_W-1:0] word,
                                        input logic stream_end);
      logic [12:0]                 count;
      logic                        bit_val;
      logic [sbfd_pkg::BYTE_W-1:0] packed_byte;
      count   = word[15:3];
      bit_val = (word == sbfd_pkg::ONE_WORD);
      case (dfr_phase)
         sbfd_pkg::PH_LEN: begin
            if (count > MAX_BYTES) begin
               restart_frame();
               expect_result(sbfd_pkg::ST_BADLEN, '0, 1'b0);
            end else if (count == 0) begin
               restart_frame();
               expect_result(sbfd_pkg::ST_EMPTY, '0, 1'b0);
            end else if (stream_end) begin
               restart_frame();
               expect_result(sbfd_pkg::ST_TRUNC, '0, 1'b0);
            end else begin
               dfr_frame_bytes = count[3:0];
               dfr_bytes_done  = '0;
               dfr_bit_index   = '0;
               dfr_bit_shift   = '0;
               dfr_phase       = sbfd_pkg::PH_DATA;
            end
         end
         sbfd_pkg::PH_DATA: begin
            if (dfr_bit_index < 3'd7) begin
               dfr_bit_shift = {dfr_bit_shift[5:0], bit_val};
               dfr_bit_index = dfr_bit_index + 3'd1;
               if (stream_end) begin
                  restart_frame();
                  expect_result(sbfd_pkg::ST_TRUNC, '0, 1'b0);
               end
            end else begin
               packed_byte    = {dfr_bit_shift, bit_val};
               dfr_bytes_done = dfr_bytes_done + 4'd1;
               dfr_bit_index  = '0;
               dfr_bit_shift  = '0;
               if (dfr_bytes_done >= dfr_frame_bytes) begin
                  restart_frame();
                  expect_result(sbfd_pkg::ST_BYTE, packed_byte, 1'b1);
               end else if (stream_end) begin
                  restart_frame();
                  expect_result(sbfd_pkg::ST_TRUNC, '0, 1'b0);
               end else begin
                  expect_result(sbfd_pkg::ST_BYTE, packed_byte, 1'b0);
               end
            end
         end
         default: begin
            restart_frame();
            if (stream_end) begin
               expect_result(sbfd_pkg::ST_TRUNC, '0, 1'b0);
            end else begin
               dfr_phase = sbfd_pkg::PH_LEN;
            end
         end
      endcase
   endfunction

   task automatic send_word(input logic [sbfd_pkg::WORD_W-1:0] word, input logic stream_end);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_word       <= word;
      req_stream_end <= stream_end;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      deframe_word(word, stream_end);
      words_sent++;
   endtask

   // Each rsp transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      deframed_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d byte_value 0x%02h last_byte %0d",
                   rsp_status, rsp_byte_value, rsp_last_byte);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_byte_value !== want.byte_value) begin
               $error("byte_value: expected 0x%02h, actual 0x%02h",
                      want.byte_value, rsp_byte_value);
               mismatch_count++;
            end
            if (rsp_last_byte !== want.last_byte) begin
               $error("last_byte: expected %0d, actual %0d", want.last_byte, rsp_last_byte);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   task automatic test_directed_cases();
      // A full one-byte frame whose last word also ends the stream.
      send_word(16'h1234, 1'b0);
      send_word(16'h0008, 1'b0);
      send_word(sbfd_pkg::ONE_WORD, 1'b0);
      send_word(16'h0080, 1'b0);
      send_word(16'h0181, 1'b0);
      send_word(sbfd_pkg::ONE_WORD, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(sbfd_pkg::ONE_WORD, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(sbfd_pkg::ONE_WORD, 1'b1);
      // A bit count below eight gives an empty packet, also at the end of the stream.
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0007, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h0000, 1'b1);
      // Lengths over the maximum, with and without the end of the stream.
      send_word(16'h5A5A, 1'b0);
      send_word(16'd88, 1'b0);
      send_word(16'hA5A5, 1'b0);
      send_word(16'hFFFF, 1'b1);
      // The stream ends on a sync word and on a valid length word.
      send_word(16'h8000, 1'b1);
      send_word(16'h7FFF, 1'b0);
      send_word(16'h0010, 1'b1);
      // A maximum frame with dropped remainder bits, cut off inside its first byte.
      send_word(16'h0001, 1'b0);
      send_word(16'd87, 1'b0);
      send_word(sbfd_pkg::ONE_WORD, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(sbfd_pkg::ONE_WORD, 1'b1);
   endtask

   task automatic test_random_frames(input int unsigned word_budget);
      int unsigned                 stop_at;
      int unsigned                 kind;
      int unsigned                 nbytes;
      int unsigned                 n_words;
      int unsigned                 end_at;
      int unsigned                 roll;
      logic [sbfd_pkg::WORD_W-1:0] word;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            nbytes  = ($urandom_range(3) == 0) ? MAX_BYTES : $urandom_range(MAX_BYTES, 1);
            n_words = 2 + nbytes * 8;
            roll    = $urandom_range(99);
            if (roll < 15) begin
               end_at = $urandom_range(n_words - 1, 0);
            end else if (roll < 25) begin
               end_at = n_words - 1;
            end else begin
               end_at = n_words;
            end
            for (int i = 0; i < n_words; i++) begin
               if (i == 0) begin
                  word = 16'($urandom);
               end else if (i == 1) begin
                  word = 16'(nbytes * 8 + $urandom_range(7));
               end else begin
                  roll = $urandom_range(3);
                  if (roll < 2) begin
                     word = sbfd_pkg::ONE_WORD;
                  end else if (roll == 2) begin
                     word = 16'($urandom);
                  end else begin
                     word = sbfd_pkg::ONE_WORD ^ (16'd1 << $urandom_range(15));
                  end
               end
               send_word(word, i == end_at);
               if (i == end_at) break;
            end
         end else if (kind < 80) begin
            send_word(16'($urandom), 1'b0);
            send_word(16'($urandom_range(7)), $urandom_range(9) == 0);
         end else if (kind < 90) begin
            send_word(16'($urandom), 1'b0);
            send_word(16'($urandom_range(16'hFFFF, 88)), $urandom_range(9) == 0);
         end else begin
            n_words = $urandom_range(6, 1);
            for (int i = 0; i < n_words; i++) begin
               send_word(16'($urandom), $urandom_range(19) == 0);
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 20;
      receiver_idle_pct = 83;
      test_directed_cases();
      test_random_frames(660);

      sender_idle_pct   = 83;
      receiver_idle_pct = 20;
      test_random_frames(660);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_frames(660);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("soft_bit_frame_deframer_core test passed");
      end else begin
         $display("soft_bit_frame_deframer_core test failed");
      end
      $finish;
   end

endmodule
